>>> src/ocp_pkg.sv
// Shared types and constants for the order crossover block.
package ocp_pkg;

	// Gene and position field widths
	localparam int GENE_W = 6;
	localparam int POS_W = 6;
	localparam int NUM_GENE_VALUES = 2 ** GENE_W;

	// Length register
	localparam int LEN_REG_W = 7;
	localparam logic [LEN_REG_W-1:0] LEN_RESET = 7'd64;

	// One loaded position as it sits in the parent store
	typedef struct packed {
		logic              keep;
		logic [GENE_W-1:0] sp;
		logic [GENE_W-1:0] fp;
	} load_item_t;

	// Write request from the load side into the parent store
	typedef struct packed {
		logic       we;
		load_item_t item;
	} load_wr_t;

	// Sequencer phases
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_MARK  = 4'b0010,
		ST_SPLIT = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

endpackage

>>> src/ocp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ocp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> src/ocp_core.sv
// Crossover sequencer: marks refill genes, splits the second parent, emits both children.
module ocp_core #(
	parameter int MAX_GENES = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [$clog2(MAX_GENES+1)-1:0]     len,
	input  ocp_pkg::load_wr_t                  ld,
	input  logic [$clog2(MAX_GENES)-1:0]       ld_addr,
	output logic                               idle,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [ocp_pkg::POS_W-1:0]          position,
	output logic [ocp_pkg::GENE_W-1:0]         child_one_gene,
	output logic [ocp_pkg::GENE_W-1:0]         child_two_gene,
	output logic                               last_result
);

	localparam int AW = $clog2(MAX_GENES);
	localparam int LW = $clog2(MAX_GENES + 1);
	localparam int IW = $bits(ocp_pkg::load_item_t);

	ocp_pkg::state_t state_q;
	logic [AW-1:0] pos_q;
	logic          use_q;
	logic [LW-1:0] len_q;
	logic [LW-1:0] c1_q, c2_q, k1_q, k2_q;
	logic [ocp_pkg::NUM_GENE_VALUES-1:0] flag_q;

	ocp_pkg::load_item_t rd_item;
	logic [IW-1:0]       rd_word;
	logic [ocp_pkg::GENE_W-1:0] q1_rdata, q2_rdata;

	logic pos_last, split_hit, q1_we, q2_we, out_free, emit_fire;

	logic                        out_valid_q;
	logic [ocp_pkg::POS_W-1:0]   position_q;
	logic [ocp_pkg::GENE_W-1:0]  c1_gene_q, c2_gene_q;
	logic                        last_q;

	// Parent store: one word per position
	ocp_ram #(.WIDTH(IW), .DEPTH(MAX_GENES)) u_par_ram (
		.clk  (clk),
		.we   (ld.we),
		.waddr(ld_addr),
		.wdata(ld.item),
		.raddr(pos_q),
		.rdata(rd_word)
	);
	assign rd_item = ocp_pkg::load_item_t'(rd_word);

	// Refill queue for child one (genes from first parent's unkept positions)
	ocp_ram #(.WIDTH(ocp_pkg::GENE_W), .DEPTH(MAX_GENES)) u_q1_ram (
		.clk  (clk),
		.we   (q1_we),
		.waddr(c1_q[AW-1:0]),
		.wdata(rd_item.sp),
		.raddr(k1_q[AW-1:0]),
		.rdata(q1_rdata)
	);

	// Refill queue for child two (all other second-parent genes)
	ocp_ram #(.WIDTH(ocp_pkg::GENE_W), .DEPTH(MAX_GENES)) u_q2_ram (
		.clk  (clk),
		.we   (q2_we),
		.waddr(c2_q[AW-1:0]),
		.wdata(rd_item.sp),
		.raddr(k2_q[AW-1:0]),
		.rdata(q2_rdata)
	);

	// Step decode
	assign pos_last  = ((LW'(pos_q) + LW'(1)) == len_q);
	assign split_hit = flag_q[rd_item.sp];
	assign q1_we     = (state_q == ocp_pkg::ST_SPLIT) && use_q && split_hit;
	assign q2_we     = (state_q == ocp_pkg::ST_SPLIT) && use_q && !split_hit;
	assign out_free  = !out_valid_q || out_ready;
	assign emit_fire = (state_q == ocp_pkg::ST_EMIT) && use_q && out_free;
	assign idle      = (state_q == ocp_pkg::ST_IDLE);

	// Sequencer: for each position it sets the store address, then uses the read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ocp_pkg::ST_IDLE;
			pos_q   <= '0;
			use_q   <= 1'b0;
			len_q   <= '0;
			c1_q    <= '0;
			c2_q    <= '0;
			k1_q    <= '0;
			k2_q    <= '0;
			flag_q  <= '0;
		end else begin
			case (state_q)
				ocp_pkg::ST_IDLE: begin
					if (start) begin
						len_q  <= len;
						pos_q  <= '0;
						use_q  <= 1'b0;
						flag_q <= '0;
						c1_q   <= '0;
						c2_q   <= '0;
						k1_q   <= '0;
						k2_q   <= '0;
						if (len != '0) begin
							state_q <= ocp_pkg::ST_MARK;
						end
					end
				end
				ocp_pkg::ST_MARK: begin
					if (!use_q) begin
						use_q <= 1'b1;
					end else begin
						use_q <= 1'b0;
						if (!rd_item.keep) begin
							flag_q[rd_item.fp] <= 1'b1;
						end
						if (pos_last) begin
							pos_q   <= '0;
							state_q <= ocp_pkg::ST_SPLIT;
						end else begin
							pos_q <= pos_q + AW'(1);
						end
					end
				end
				ocp_pkg::ST_SPLIT: begin
					if (!use_q) begin
						use_q <= 1'b1;
					end else begin
						use_q <= 1'b0;
						if (split_hit) begin
							c1_q <= c1_q + LW'(1);
						end else begin
							c2_q <= c2_q + LW'(1);
						end
						if (pos_last) begin
							pos_q   <= '0;
							state_q <= ocp_pkg::ST_EMIT;
						end else begin
							pos_q <= pos_q + AW'(1);
						end
					end
				end
				ocp_pkg::ST_EMIT: begin
					if (!use_q) begin
						use_q <= 1'b1;
					end else if (out_free) begin
						use_q <= 1'b0;
						if (rd_item.keep) begin
							k2_q <= k2_q + LW'(1);
						end else begin
							k1_q <= k1_q + LW'(1);
						end
						if (pos_last) begin
							state_q <= ocp_pkg::ST_IDLE;
						end else begin
							pos_q <= pos_q + AW'(1);
						end
					end
				end
				default: begin
					state_q <= ocp_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload; an empty refill slot gives zero
	always_ff @(posedge clk) begin
		if (emit_fire) begin
			position_q <= ocp_pkg::POS_W'(pos_q);
			last_q     <= pos_last;
			if (rd_item.keep) begin
				c1_gene_q <= rd_item.fp;
				c2_gene_q <= (k2_q < c2_q) ? q2_rdata : '0;
			end else begin
				c2_gene_q <= rd_item.fp;
				c1_gene_q <= (k1_q < c1_q) ? q1_rdata : '0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign position       = position_q;
	assign child_one_gene = c1_gene_q;
	assign child_two_gene = c2_gene_q;
	assign last_result    = last_q;

endmodule

>>> src/order_crossover_permutation.sv
// Order crossover of two permutation chromosomes: top level.
//
// Input channel (in_valid/in_ready): one item per chromosome position, in order
// from position 0, carrying both parents' genes and the keep flag. The item with
// last_position set closes the load and starts the crossover.
// Config channel (cfg_valid/cfg_ready): writes chromosome_length; the length
// used is the smaller of it and MAX_GENES. Write it only while the block is idle.
// Output channel (out_valid/out_ready): one item per position 0..L-1 with both
// children's genes; last_result marks position L-1. A length of zero emits nothing.
// Loading accepts one item per cycle. After the last item the sequencer makes
// three passes over the parent store (mark, split, emit); each pass reads the
// store position by position through its one registered port, setting the
// address of a position before it uses the data. in_ready stays low during
// the passes.
// Reset: length reads 64, the load counter is zero, the output register is empty.
// A stalled receiver holds the output item and pauses the emit pass.
module order_crossover_permutation #(
	parameter int MAX_GENES = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ocp_pkg::LEN_REG_W-1:0]      chromosome_length,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [ocp_pkg::GENE_W-1:0]         first_parent_gene,
	input  logic [ocp_pkg::GENE_W-1:0]         second_parent_gene,
	input  logic                               keep_for_first,
	input  logic                               last_position,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [ocp_pkg::POS_W-1:0]          position,
	output logic [ocp_pkg::GENE_W-1:0]         child_one_gene,
	output logic [ocp_pkg::GENE_W-1:0]         child_two_gene,
	output logic                               last_result
);

	localparam int AW = $clog2(MAX_GENES);
	localparam int LW = $clog2(MAX_GENES + 1);

	logic [ocp_pkg::LEN_REG_W-1:0] len_reg_q;
	logic [LW-1:0]                 load_count_q;
	logic [LW-1:0]                 eff_len;
	logic                          in_fire, room, core_idle;
	ocp_pkg::load_wr_t             ld;

	// Length register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_reg_q <= ocp_pkg::LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			len_reg_q <= chromosome_length;
		end
	end

	// Length in use, clipped to the store depth
	assign eff_len = (len_reg_q > ocp_pkg::LEN_REG_W'(MAX_GENES))
		? LW'(MAX_GENES) : LW'(len_reg_q);

	// Load side: items past the store depth are dropped
	assign in_ready     = core_idle;
	assign in_fire      = in_valid && in_ready;
	assign room         = (load_count_q < LW'(MAX_GENES));
	assign ld.we        = in_fire && room;
	assign ld.item.fp   = first_parent_gene;
	assign ld.item.sp   = second_parent_gene;
	assign ld.item.keep = keep_for_first;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_count_q <= '0;
		end else if (in_fire) begin
			if (last_position) begin
				load_count_q <= '0;
			end else if (room) begin
				load_count_q <= load_count_q + LW'(1);
			end
		end
	end

	// Crossover sequencer with its stores and output register
	ocp_core #(.MAX_GENES(MAX_GENES)) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (in_fire && last_position),
		.len           (eff_len),
		.ld            (ld),
		.ld_addr       (load_count_q[AW-1:0]),
		.idle          (core_idle),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.position      (position),
		.child_one_gene(child_one_gene),
		.child_two_gene(child_two_gene),
		.last_result   (last_result)
	);

endmodule

>>> tb/order_crossover_permutation_tb.sv
// Self-checking testbench for the order crossover block: directed and random crossovers.
module order_crossover_permutation_tb;

	localparam int MAX_GENES = 64;
	localparam int NO_WRITE = -1;
	localparam int TOTAL_ITEMS = 460;
	localparam int CALM_ITEMS = 380;     // no idling once this many items went in
	localparam int SETTLE_CYCLES = 20;
	localparam int CYCLE_LIMIT = 4000000;
	localparam int SEQ_MAX = 72;

	typedef logic [ocp_pkg::GENE_W-1:0] gene_t;
	typedef gene_t gene_seq_t [SEQ_MAX];

	// One result position as the block should emit it
	typedef struct {
		logic [ocp_pkg::POS_W-1:0] pos;
		gene_t                     one;
		gene_t                     two;
		logic                      fin;
	} child_pos_t;

	// One directed item, with an optional length write ahead of it
	typedef struct {
		int    len;
		gene_t fp;
		gene_t sp;
		logic  keep;
		logic  last;
		bit    typed;
		gene_t c1;
		gene_t c2;
	} stim_row_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [ocp_pkg::LEN_REG_W-1:0] chromosome_length = '0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	gene_t                         first_parent_gene = '0;
	gene_t                         second_parent_gene = '0;
	logic                          keep_for_first = 1'b0;
	logic                          last_position = 1'b0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [ocp_pkg::POS_W-1:0]     position;
	gene_t                         child_one_gene;
	gene_t                         child_two_gene;
	logic                          last_result;

	// Predictor state
	gene_t      fp_store [MAX_GENES];
	gene_t      sp_store [MAX_GENES];
	logic       keep_store [MAX_GENES];
	int         loaded = 0;
	int         len_setting = 64;
	bit         typed_ok [MAX_GENES];
	gene_t      typed_c1 [MAX_GENES];
	gene_t      typed_c2 [MAX_GENES];
	child_pos_t children_due [$];

	int fails = 0;
	int items_sent = 0;
	int cycles = 0;
	bit send_gaps = 1'b0;
	bit recv_stalls = 1'b0;

	// Directed rows: extremes, all kept, all unkept, repeated genes, stale load,
	// zero length, length one
	stim_row_t directed_rows [22] = '{
		'{2,        0,  63, 1, 0, 1, 0,  0},
		'{NO_WRITE, 63, 0,  0, 1, 1, 63, 63},
		'{4,        1,  3,  1, 0, 0, 0,  0},
		'{NO_WRITE, 2,  0,  1, 0, 0, 0,  0},
		'{NO_WRITE, 3,  2,  0, 0, 0, 0,  0},
		'{NO_WRITE, 0,  1,  0, 1, 0, 0,  0},
		'{NO_WRITE, 5,  8,  1, 0, 1, 5,  8},
		'{NO_WRITE, 6,  7,  1, 0, 1, 6,  7},
		'{NO_WRITE, 7,  6,  1, 0, 1, 7,  6},
		'{NO_WRITE, 8,  5,  1, 1, 1, 8,  5},
		'{NO_WRITE, 10, 40, 0, 0, 1, 40, 10},
		'{NO_WRITE, 20, 30, 0, 0, 1, 30, 20},
		'{NO_WRITE, 30, 20, 0, 0, 1, 20, 30},
		'{NO_WRITE, 40, 10, 0, 1, 1, 10, 40},
		'{NO_WRITE, 1,  1,  0, 0, 0, 0,  0},
		'{NO_WRITE, 1,  1,  0, 0, 0, 0,  0},
		'{NO_WRITE, 2,  1,  1, 0, 0, 0,  0},
		'{NO_WRITE, 3,  5,  1, 1, 0, 0,  0},
		'{NO_WRITE, 9,  9,  1, 0, 0, 0,  0},
		'{NO_WRITE, 4,  4,  0, 1, 0, 0,  0},
		'{0,        63, 63, 1, 1, 0, 0,  0},
		'{1,        17, 42, 0, 1, 1, 0,  17}
	};

	order_crossover_permutation #(
		.MAX_GENES(MAX_GENES)
	) dut (.*);

	always #5 clk = ~clk;

	// Store one position; on the last one build both children and queue them
	function automatic void cross_parents(gene_t fp, gene_t sp, logic keep, logic last);
		int         len;
		int         i;
		int         n_one;
		int         n_two;
		int         used_one;
		int         used_two;
		int         slot_one [MAX_GENES];
		int         slot_two [MAX_GENES];
		bit         refill [ocp_pkg::NUM_GENE_VALUES];
		gene_t      c1 [MAX_GENES];
		gene_t      c2 [MAX_GENES];
		gene_t      g;
		child_pos_t r;
		if (loaded < MAX_GENES) begin
			fp_store[loaded] = fp;
			sp_store[loaded] = sp;
			keep_store[loaded] = keep;
			loaded++;
		end
		if (!last)
			return;
		len = (len_setting > MAX_GENES) ? MAX_GENES : len_setting;
		n_one = 0;
		n_two = 0;
		used_one = 0;
		used_two = 0;
		for (i = 0; i < ocp_pkg::NUM_GENE_VALUES; i++)
			refill[i] = 1'b0;
		// kept genes go to child one, unkept to child two
		for (i = 0; i < len; i++) begin
			g = fp_store[i];
			if (keep_store[i]) begin
				c1[i] = g;
				c2[i] = '0;
				slot_two[n_two++] = i;
			end else begin
				c2[i] = g;
				c1[i] = '0;
				slot_one[n_one++] = i;
				refill[g] = 1'b1;
			end
		end
		// fill the open slots in second-parent order; surplus genes drop
		for (i = 0; i < len; i++) begin
			g = sp_store[i];
			if (refill[g]) begin
				if (used_one < n_one)
					c1[slot_one[used_one++]] = g;
			end else if (used_two < n_two) begin
				c2[slot_two[used_two++]] = g;
			end
		end
		for (i = 0; i < len; i++) begin
			r.pos = ocp_pkg::POS_W'(i);
			r.one = typed_ok[i] ? typed_c1[i] : c1[i];
			r.two = typed_ok[i] ? typed_c2[i] : c2[i];
			r.fin = (i == len - 1);
			children_due.push_back(r);
		end
		loaded = 0;
		for (i = 0; i < MAX_GENES; i++)
			typed_ok[i] = 1'b0;
	endfunction

	function automatic void shuffle_genes(ref gene_seq_t g, input int count);
		int    j;
		int    k;
		gene_t t;
		for (j = count - 1; j > 0; j--) begin
			k = $urandom_range(0, j);
			t = g[j];
			g[j] = g[k];
			g[k] = t;
		end
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$error("%s expected %0d actual %0d", name, want, got);
			fails++;
		end
	endfunction

	// Offer one item, with an occasional gap ahead of it, and wait for acceptance
	task automatic send_item(gene_t fp, gene_t sp, logic keep, logic last);
		if (send_gaps && items_sent < CALM_ITEMS && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		first_parent_gene <= fp;
		second_parent_gene <= sp;
		keep_for_first <= keep;
		last_position <= last;
		do @(posedge clk); while (!in_ready);
		cross_parents(fp, sp, keep, last);
		items_sent++;
	endtask

	// Hold the sender until every pending result is out and the block settles
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (children_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_length(int value);
		wait_drained();
		cfg_valid <= 1'b1;
		chromosome_length <= ocp_pkg::LEN_REG_W'(value);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		len_setting = value;
	endtask

	// One random chromosome: mostly permutations of matching length
	task automatic random_chromosome(int idx);
		int        new_len;
		int        eff;
		int        n;
		int        m;
		int        pick;
		int        a;
		int        b;
		int        j;
		bit        noise;
		gene_seq_t pool;
		gene_seq_t fps;
		gene_seq_t sps;
		logic      keeps [SEQ_MAX];
		new_len = len_setting;
		if (idx == 0)
			new_len = MAX_GENES;
		else if (idx == 1)
			new_len = 127;
		else if (len_setting > 12 || $urandom_range(0, 2) == 0) begin
			pick = $urandom_range(0, 99);
			if (pick < 70)
				new_len = $urandom_range(2, 12);
			else if (pick < 80)
				new_len = $urandom_range(13, 63);
			else if (pick < 88)
				new_len = MAX_GENES;
			else if (pick < 95)
				new_len = $urandom_range(65, 127);
			else
				new_len = $urandom_range(0, 1);
		end
		if (new_len != len_setting)
			write_length(new_len);
		eff = (new_len > MAX_GENES) ? MAX_GENES : new_len;

		// item count: matching, short (stale tail), long, or past the store
		pick = $urandom_range(0, 99);
		if (idx == 0)
			n = MAX_GENES;
		else if (idx == 1 || pick >= 96)
			n = $urandom_range(MAX_GENES + 1, MAX_GENES + 6);
		else if (pick < 76 && eff > 0)
			n = eff;
		else if (pick < 88 && eff > 1)
			n = $urandom_range(1, eff - 1);
		else
			n = $urandom_range(eff + 1, eff + 4);

		// parents: second is a reordering of the first, unless noise
		for (j = 0; j < SEQ_MAX; j++)
			pool[j] = gene_t'(j);
		shuffle_genes(pool, ocp_pkg::NUM_GENE_VALUES);
		m = (n < MAX_GENES) ? n : MAX_GENES;
		for (j = 0; j < n; j++) begin
			fps[j] = pool[j % ocp_pkg::NUM_GENE_VALUES];
			sps[j] = (j < m) ? fps[j] : gene_t'($urandom);
		end
		shuffle_genes(sps, m);
		noise = (idx > 1) && ($urandom_range(0, 4) == 0);
		if (noise) begin
			for (j = 0; j < n; j++) begin
				fps[j] = gene_t'($urandom);
				sps[j] = gene_t'($urandom);
			end
		end

		// keep mask: one kept segment, random bits, all kept or none kept
		pick = $urandom_range(0, 9);
		a = $urandom_range(0, n - 1);
		b = $urandom_range(a, n - 1);
		for (j = 0; j < n; j++) begin
			if (pick < 5)
				keeps[j] = (j >= a && j <= b);
			else if (pick < 8)
				keeps[j] = 1'($urandom_range(0, 1));
			else
				keeps[j] = (pick == 8);
		end

		send_gaps = ($urandom_range(0, 2) != 0);
		recv_stalls = ($urandom_range(0, 2) != 0);
		for (j = 0; j < n; j++)
			send_item(fps[j], sps[j], keeps[j], j == n - 1);
		if ($urandom_range(0, 7) == 0)
			wait_drained();
	endtask

	// Stimulus
	initial begin
		int r;
		int idx;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_gaps = 1'b1;
		recv_stalls = 1'b1;
		for (r = 0; r < $size(directed_rows); r++) begin
			if (directed_rows[r].len != NO_WRITE)
				write_length(directed_rows[r].len);
			if (loaded < MAX_GENES) begin
				typed_ok[loaded] = directed_rows[r].typed;
				typed_c1[loaded] = directed_rows[r].c1;
				typed_c2[loaded] = directed_rows[r].c2;
			end
			send_item(directed_rows[r].fp, directed_rows[r].sp,
				directed_rows[r].keep, directed_rows[r].last);
		end
		idx = 0;
		while (items_sent < TOTAL_ITEMS) begin
			random_chromosome(idx);
			idx++;
		end
		wait_drained();
		if (fails == 0)
			$display("PASS order_crossover_permutation");
		else
			$display("FAIL order_crossover_permutation");
		$finish;
	end

	// Receiver: random stall bursts while stalls are enabled
	initial begin
		@(posedge clk);
		forever begin
			if (recv_stalls && items_sent < CALM_ITEMS && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	// Compare each accepted result with the oldest pending one
	always @(posedge clk) begin
		child_pos_t want;
		if (arst_n && out_valid && out_ready) begin
			if (children_due.size() == 0) begin
				$error("result with nothing pending at position %0d", position);
				fails++;
			end else begin
				want = children_due.pop_front();
				check_field("position", 8'(want.pos), 8'(position));
				check_field("child_one_gene", 8'(want.one), 8'(child_one_gene));
				check_field("child_two_gene", 8'(want.two), 8'(child_two_gene));
				check_field("last_result", 8'(want.fin), 8'(last_result));
			end
		end
	end

	// Timeout
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL order_crossover_permutation");
			$finish;
		end
	end

endmodule

>>> order_crossover_permutation.f
src/ocp_pkg.sv
src/ocp_ram.sv
src/ocp_core.sv
src/order_crossover_permutation.sv
tb/order_crossover_permutation_tb.sv
